>>> rtl/core/etl_pkg.sv
// shared types, codes and constants of the expression token lexer
package etl_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 4;
    localparam int POS_W  = 17;
    localparam int LEN_W  = 17;
    localparam int VAL_W  = 63;

    // position saturates here
    localparam logic [POS_W-1:0] MAX_SOURCE_BYTES = POS_W'(65536);
    localparam logic [VAL_W-1:0] VAL_MAX          = {VAL_W{1'b1}};

    // scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_INT  = 2'd1;
    localparam logic [1:0] MODE_NAME = 2'd2;

    // keyword progress
    localparam logic [1:0] KW_NONE = 2'd0;
    localparam logic [1:0] KW_I    = 2'd1;
    localparam logic [1:0] KW_I6   = 2'd2;
    localparam logic [1:0] KW_I64  = 2'd3;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_END      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INT      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_NAME     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_I64      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STAR     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 4'd11;
    localparam logic [KIND_W-1:0] KIND_BAD      = 4'd12;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 4'd13;

    // result slots, in emission order
    localparam int SLOT_N = 4;
    localparam int SLOT_W = 2;
    localparam int SLOT_FLUSH  = 0;
    localparam int SLOT_SINGLE = 1;
    localparam int SLOT_TAIL   = 2;
    localparam int SLOT_END    = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  value;
    } token_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] start;
        logic [VAL_W-1:0] acc;
        logic             ovf;
        logic [1:0]       kw;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:  MODE_IDLE,
        pos:   '0,
        start: '0,
        acc:   '0,
        ovf:   1'b0,
        kw:    KW_NONE
    };

endpackage

>>> rtl/core/etl_byte_if.sv
// valid/ready channel carrying one source byte word
interface etl_byte_if;
    import etl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              byte_present;
    logic              source_end;

    modport source (output valid, byte_value, byte_present, source_end, input ready);
    modport sink (input valid, byte_value, byte_present, source_end, output ready);
    modport monitor (input valid, ready, byte_value, byte_present, source_end);
endinterface

>>> rtl/core/etl_token_if.sv
// valid/ready channel carrying one token word
interface etl_token_if;
    import etl_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  token_offset;
    logic [LEN_W-1:0]  token_length;
    logic [VAL_W-1:0]  int_value;
    logic              last_of_run;

    modport source (output valid, token_kind, token_offset, token_length, int_value,
                    last_of_run, input ready);
    modport sink (input valid, token_kind, token_offset, token_length, int_value,
                  last_of_run, output ready);
    modport monitor (input valid, ready, token_kind, token_offset, token_length, int_value,
                     last_of_run);
endinterface

>>> rtl/core/etl_scan.sv
// per-byte scan step: next scan state and the candidate tokens of one byte
module etl_scan (
    input  etl_pkg::scan_state_t                 cur,
    input  logic [etl_pkg::BYTE_W-1:0]           byte_value,
    input  logic                                 byte_present,
    input  logic                                 source_end,
    output etl_pkg::scan_state_t                 nxt,
    output etl_pkg::token_t [etl_pkg::SLOT_N-1:0] slot_tok,
    output logic [etl_pkg::SLOT_N-1:0]           slot_vld
);
    import etl_pkg::*;

    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5f;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
    localparam logic [BYTE_W-1:0] CH_4     = 8'h34;

    function automatic token_t flush_tok(scan_state_t s);
        token_t t;
        t        = '0;
        t.offset = s.start;
        if (s.mode == MODE_INT)
        begin
            t.kind  = s.ovf ? KIND_OVERFLOW : KIND_INT;
            t.value = s.acc;
        end
        else if (s.kw == KW_I64)
        begin
            t.kind = KIND_I64;
        end
        else
        begin
            t.kind   = KIND_NAME;
            t.length = s.pos - s.start;
        end
        return t;
    endfunction

    logic              is_digit;
    logic              is_alpha;
    logic              is_space;
    logic [3:0]        digit;
    logic [VAL_W+3:0]  acc10;
    logic              refuse;
    logic [POS_W-1:0]  pos_adv;
    logic [KIND_W-1:0] single_kind;
    scan_state_t       s1;

    assign is_digit = (byte_value >= CH_0) && (byte_value <= CH_9);
    assign is_alpha = ((byte_value >= CH_LA) && (byte_value <= CH_LZ))
                   || ((byte_value >= CH_UA) && (byte_value <= CH_UZ))
                   || (byte_value == CH_UNDER);
    assign is_space = (byte_value == CH_SPACE) || (byte_value == CH_TAB)
                   || (byte_value == CH_CR) || (byte_value == CH_LF);
    assign digit    = byte_value[3:0];

    // value*10 + digit, refused when it would pass the signed 64-bit limit
    assign acc10  = ({4'b0000, cur.acc} << 3) + ({4'b0000, cur.acc} << 1)
                  + {{VAL_W{1'b0}}, digit};
    assign refuse = acc10 > {4'b0000, VAL_MAX};

    assign pos_adv = (cur.pos < MAX_SOURCE_BYTES) ? POS_W'(cur.pos + 1'b1) : cur.pos;

    always_comb
    begin
        unique case (byte_value)
            8'h2b:   single_kind = KIND_PLUS;
            8'h2d:   single_kind = KIND_MINUS;
            8'h2a:   single_kind = KIND_STAR;
            8'h2f:   single_kind = KIND_SLASH;
            8'h3d:   single_kind = KIND_ASSIGN;
            8'h3b:   single_kind = KIND_SEMI;
            8'h28:   single_kind = KIND_LPAREN;
            8'h29:   single_kind = KIND_RPAREN;
            default: single_kind = KIND_BAD;
        endcase
    end

    always_comb
    begin
        s1       = cur;
        slot_tok = '0;
        slot_vld = '0;

        if (byte_present)
        begin
            s1.pos = pos_adv;
            priority if (cur.mode == MODE_INT && is_digit)
            begin
                if (refuse)
                    s1.ovf = 1'b1;
                else
                    s1.acc = acc10[VAL_W-1:0];
            end
            else if (cur.mode == MODE_NAME && (is_alpha || is_digit))
            begin
                if (cur.kw == KW_I && byte_value == CH_6)
                    s1.kw = KW_I6;
                else if (cur.kw == KW_I6 && byte_value == CH_4)
                    s1.kw = KW_I64;
                else
                    s1.kw = KW_NONE;
            end
            else
            begin
                // current token ends here
                slot_vld[SLOT_FLUSH] = (cur.mode != MODE_IDLE);
                slot_tok[SLOT_FLUSH] = flush_tok(cur);
                s1.mode = MODE_IDLE;
                if (is_digit)
                begin
                    s1.mode  = MODE_INT;
                    s1.start = cur.pos;
                    s1.acc   = {{(VAL_W-4){1'b0}}, digit};
                    s1.ovf   = 1'b0;
                end
                else if (is_alpha)
                begin
                    s1.mode  = MODE_NAME;
                    s1.start = cur.pos;
                    s1.kw    = (byte_value == CH_I) ? KW_I : KW_NONE;
                end
                else if (!is_space)
                begin
                    slot_vld[SLOT_SINGLE]        = 1'b1;
                    slot_tok[SLOT_SINGLE].kind   = single_kind;
                    slot_tok[SLOT_SINGLE].offset = cur.pos;
                end
            end
        end

        nxt = s1;
        if (source_end)
        begin
            slot_vld[SLOT_TAIL]       = (s1.mode != MODE_IDLE);
            slot_tok[SLOT_TAIL]       = flush_tok(s1);
            slot_vld[SLOT_END]        = 1'b1;
            slot_tok[SLOT_END].kind   = KIND_END;
            slot_tok[SLOT_END].offset = s1.pos;
            nxt = SCAN_RESET;
        end
    end

endmodule

>>> rtl/core/expression_token_lexer.sv
// top level of the expression token lexer: byte register, scan step and token buffer
//
// source_bytes carries one byte word per handshake (byte_value, byte_present,
// source_end); tokens carries one token word per handshake, last_of_run marking
// the final token that a byte word caused.
// a byte word is taken into the byte register, scanned at the next edge at
// which the token buffer is free, and its tokens are registered in the buffer
// and shown from it one per handshake, lowest slot first.
// throughput is one byte word per cycle while each byte gives at most one
// token and the receiver does not stall; a byte that gives several tokens (at
// most three) holds the scan stage until the single token port has drained
// them from the buffer.
// reset clears the scan state (position zero, between tokens), the byte
// register and the buffer. when the receiver stalls, the buffered tokens hold
// steady, one further byte word is taken into the byte register, and then
// ready drops until the buffer drains. the position count saturates at
// MAX_SOURCE_BYTES; the end of a source returns the scan state to reset
module expression_token_lexer (
    input  logic        clk,
    input  logic        rst_n,
    etl_byte_if.sink    source_bytes,
    etl_token_if.source tokens
);
    import etl_pkg::*;

    // byte register
    logic              item_valid_reg;
    logic [BYTE_W-1:0] item_value_reg;
    logic              item_present_reg;
    logic              item_end_reg;

    // scan state
    scan_state_t state_reg;
    scan_state_t state_next;

    // token buffer: one slot per possible token of a byte, sent lowest first
    token_t [SLOT_N-1:0] slot_reg;
    token_t [SLOT_N-1:0] slot_next;
    logic   [SLOT_N-1:0] mask_reg;
    logic   [SLOT_N-1:0] mask_next;

    logic [SLOT_W-1:0] sel_idx;
    logic [SLOT_N-1:0] sel_bit;
    logic [SLOT_N-1:0] rest;
    logic              out_fire;
    logic              buf_free;
    logic              item_take;

    etl_scan u_scan (
        .cur          (state_reg),
        .byte_value   (item_value_reg),
        .byte_present (item_present_reg),
        .source_end   (item_end_reg),
        .nxt          (state_next),
        .slot_tok     (slot_next),
        .slot_vld     (mask_next)
    );

    // oldest pending token
    always_comb
    begin
        priority if (mask_reg[0])
            sel_idx = SLOT_W'(0);
        else if (mask_reg[1])
            sel_idx = SLOT_W'(1);
        else if (mask_reg[2])
            sel_idx = SLOT_W'(2);
        else
            sel_idx = SLOT_W'(3);
    end

    assign sel_bit  = SLOT_N'(1) << sel_idx;
    assign rest     = mask_reg & ~sel_bit;
    assign out_fire = tokens.valid && tokens.ready;

    // buffer is free once its last token leaves
    assign buf_free  = (mask_reg == '0) || ((rest == '0) && out_fire);
    assign item_take = item_valid_reg && buf_free;

    assign source_bytes.ready = !item_valid_reg || item_take;

    assign tokens.valid        = |mask_reg;
    assign tokens.token_kind   = slot_reg[sel_idx].kind;
    assign tokens.token_offset = slot_reg[sel_idx].offset;
    assign tokens.token_length = slot_reg[sel_idx].length;
    assign tokens.int_value    = slot_reg[sel_idx].value;
    assign tokens.last_of_run  = (rest == '0);

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (source_bytes.valid && source_bytes.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (source_bytes.valid && source_bytes.ready)
        begin
            item_value_reg   <= source_bytes.byte_value;
            item_present_reg <= source_bytes.byte_present;
            item_end_reg     <= source_bytes.source_end;
        end
    end

    // scan state and buffer mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
            mask_reg  <= '0;
        end
        else if (item_take)
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
        end
        else if (out_fire)
        begin
            mask_reg <= rest;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

>>> rtl/core/etl_checker.sv
// port-level checker for the expression token lexer, bound to the top level
module etl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         token_valid,
    input logic                         token_ready,
    input logic [etl_pkg::KIND_W-1:0]   token_kind,
    input logic [etl_pkg::POS_W-1:0]    token_offset,
    input logic [etl_pkg::LEN_W-1:0]    token_length,
    input logic [etl_pkg::VAL_W-1:0]    int_value,
    input logic                         last_of_run
);
    import etl_pkg::*;

    // stalled token word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid
            && $stable(token_kind) && $stable(token_offset)
            && $stable(token_length) && $stable(int_value)
            && $stable(last_of_run))
        else $error("token word changed while stalled");

    // end token closes the run of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == KIND_END |-> last_of_run)
        else $error("end token not marked last of run");

    // only names carry a length
    a_len_name: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != KIND_NAME |-> token_length == '0)
        else $error("length on a token that is not a name");

    // only integers carry a value
    a_val_int: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != KIND_INT && token_kind != KIND_OVERFLOW
            |-> int_value == '0)
        else $error("value on a token that is not an integer");

endmodule

bind expression_token_lexer etl_checker u_etl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .token_valid  (tokens.valid),
    .token_ready  (tokens.ready),
    .token_kind   (tokens.token_kind),
    .token_offset (tokens.token_offset),
    .token_length (tokens.token_length),
    .int_value    (tokens.int_value),
    .last_of_run  (tokens.last_of_run)
);
